@@ hw/rtl/fbps_pkg.sv @@
// ============================================================================
// fbps_pkg
// Shared types and constants of the four-bar position solver pipeline.
// ============================================================================
`default_nettype none

package fbps_pkg;

    // Angle bits taken from the input field, guard bits below the register scale
    localparam int ANGLE_BITS   = 16;
    localparam int GUARD        = 8;
    localparam int CORDIC_STEPS = 24;

    // Start vector of the rotation, 2^30 divided by the rotation gain
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Step counts of the iterative units
    localparam int SQ1_STEPS = 27;   // root of the squared A-O4 distance
    localparam int DV1_STEPS = 25;   // chord foot distance
    localparam int SQ2_STEPS = 24;   // half chord
    localparam int DV2_STEPS = 26;   // projections onto the A-O4 frame

    typedef enum logic [2:0] {
        REG_CRANK_LEN   = 3'd0,
        REG_COUPLER_LEN = 3'd1,
        REG_ROCKER_LEN  = 3'd2,
        REG_GROUND_LEN  = 3'd3,
        REG_PIVOT_X     = 3'd4,
        REG_PIVOT_Y     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } cordic_t;

    // Geometry that travels with an item
    typedef struct packed {
        logic signed [26:0] ax;
        logic signed [26:0] ay;
        logic signed [27:0] dx;
        logic signed [27:0] dy;
        logic [53:0]        d2;
        logic [26:0]        droot;
        logic signed [25:0] aa;
        logic               ok;
    } geo_t;

    typedef struct packed {
        logic [53:0] rem;
        logic [53:0] root;
    } sq_t;

    typedef struct packed {
        logic [53:0] rem;
        logic [25:0] quo;
        logic        neg;
    } dv_t;

    typedef dv_t [3:0] dv4_t;

endpackage

`default_nettype wire

@@ hw/rtl/four_bar_position_solver.sv @@
// ============================================================================
// four_bar_position_solver
// Four-bar linkage position solver, one crank angle per request.
// ============================================================================
// Write the four link lengths and the ground pivot through the cfg channel
// (index 0..5, others dropped) while no request is in flight; cfg_ready is
// always high. Each request on the s_ stream carries one crank angle and
// yields exactly one result on the m_ stream: crank joint A, both
// coupler-rocker intersections and a feasible flag in m_tuser.
// A new angle is taken every cycle in which s_tready is high: the rotation
// unit, both square roots and both dividers are unrolled into one register
// stage per iteration, so the rate is one result per cycle while the
// receiver does not stall.
// Reset clears the link registers to zero and empties the pipeline.
// When the receiver stalls, the whole pipeline holds with the result in the
// output register; s_tready drops in the same cycle and nothing is lost.
// ============================================================================
`default_nettype none

module four_bar_position_solver
    import fbps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,    // crank_angle
    output logic         m_tvalid,
    input  logic         m_tready,
    // joint_a_x, joint_a_y, root0_x, root0_y, root1_x, root1_y (20 bits each)
    output logic [119:0] m_tdata,
    output logic         m_tuser,    // feasible
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    function automatic sq_t sqrt_step(input sq_t s, input logic [53:0] bitv);
        sq_t         r;
        logic [54:0] trial;
        trial = {1'b0, s.root} + {1'b0, bitv};
        if ({1'b0, s.rem} >= trial)
        begin
            r.rem  = s.rem - trial[53:0];
            r.root = (s.root >> 1) + bitv;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    function automatic dv_t div_step(input dv_t s, input logic [53:0] den,
                                     input int sh, input logic [25:0] qbit);
        dv_t         r;
        logic [53:0] t;
        r = s;
        t = den << sh;
        if (s.rem >= t)
        begin
            r.rem = s.rem - t;
            r.quo = s.quo | qbit;
        end
        return r;
    endfunction

    function automatic logic [19:0] emit(input logic signed [27:0] v);
        logic signed [28:0] t;
        logic [19:0]        r;
        t = ($signed({v[27], v}) + 29'sd128) >>> GUARD;
        if (t > 29'sd524287)
            r = 20'h7FFFF;
        else if (t < -29'sd524288)
            r = 20'h80000;
        else
            r = t[19:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] crank_len_reg;
    logic [15:0] coupler_len_reg;
    logic [15:0] rocker_len_reg;
    logic [15:0] ground_len_reg;
    logic [15:0] pivot_x_reg;
    logic [15:0] pivot_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crank_len_reg   <= '0;
            coupler_len_reg <= '0;
            rocker_len_reg  <= '0;
            ground_len_reg  <= '0;
            pivot_x_reg     <= '0;
            pivot_y_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CRANK_LEN:   crank_len_reg   <= cfg_data;
                REG_COUPLER_LEN: coupler_len_reg <= cfg_data;
                REG_ROCKER_LEN:  rocker_len_reg  <= cfg_data;
                REG_GROUND_LEN:  ground_len_reg  <= cfg_data;
                REG_PIVOT_X:     pivot_x_reg     <= cfg_data;
                REG_PIVOT_Y:     pivot_y_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Terms that follow from the lengths alone
    logic [16:0]        bpc;
    logic [15:0]        bdc;
    logic [33:0]        sum_sq;
    logic [31:0]        dif_sq;
    logic [31:0]        b_sq;
    logic [31:0]        c_sq;
    logic [49:0]        sum2_reg;
    logic [47:0]        dif2_reg;
    logic [47:0]        bsq_reg;
    logic signed [48:0] bmc_reg;

    assign bpc    = {1'b0, coupler_len_reg} + {1'b0, rocker_len_reg};
    assign bdc    = (coupler_len_reg >= rocker_len_reg) ?
                    coupler_len_reg - rocker_len_reg : rocker_len_reg - coupler_len_reg;
    assign sum_sq = bpc * bpc;
    assign dif_sq = bdc * bdc;
    assign b_sq   = coupler_len_reg * coupler_len_reg;
    assign c_sq   = rocker_len_reg * rocker_len_reg;

    always_ff @(posedge clk)
    begin
        sum2_reg <= {sum_sq, 16'b0};
        dif2_reg <= {dif_sq, 16'b0};
        bsq_reg  <= {b_sq, 16'b0};
        bmc_reg  <= $signed({1'b0, b_sq, 16'b0}) - $signed({1'b0, c_sq, 16'b0});
    end

    logic               zero_len;
    logic signed [26:0] px27;
    logic signed [26:0] py27;
    logic signed [27:0] px28;
    logic signed [27:0] py28;

    assign zero_len = (crank_len_reg == '0) || (coupler_len_reg == '0) ||
                      (rocker_len_reg == '0) || (ground_len_reg == '0);
    assign px27 = $signed({{3{pivot_x_reg[15]}}, pivot_x_reg, 8'b0});
    assign py27 = $signed({{3{pivot_y_reg[15]}}, pivot_y_reg, 8'b0});
    assign px28 = $signed({{4{pivot_x_reg[15]}}, pivot_x_reg, 8'b0});
    assign py28 = $signed({{4{pivot_y_reg[15]}}, pivot_y_reg, 8'b0});

    // ------------------------------------------------------------------
    // Flow control: every stage advances when the output register frees
    // ------------------------------------------------------------------
    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Sine and cosine
    // ------------------------------------------------------------------
    logic               c_vld;
    logic signed [32:0] c_cos;
    logic signed [32:0] c_sin;

    fbps_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .angle     (s_tdata),
        .out_valid (c_vld),
        .cos_val   (c_cos),
        .sin_val   (c_sin)
    );

    // ------------------------------------------------------------------
    // Crank joint, A-O4 vector and its squared length
    // ------------------------------------------------------------------
    logic signed [49:0] p1_x_reg;
    logic signed [49:0] p1_y_reg;
    logic signed [49:0] rnd_x;
    logic signed [49:0] rnd_y;
    geo_t               g2_next;
    geo_t               g2_reg;
    geo_t               g3_next;
    geo_t               g3_reg;
    geo_t               g4_reg;
    logic signed [55:0] dxx;
    logic signed [55:0] dyy;
    logic [53:0]        dxx_reg;
    logic [53:0]        dyy_reg;
    logic [53:0]        d2_sum;
    geo_t               g5_next;
    logic [3:0]         pv_reg;

    assign rnd_x = (p1_x_reg + (50'sd1 <<< 21)) >>> 22;
    assign rnd_y = (p1_y_reg + (50'sd1 <<< 21)) >>> 22;

    always_comb
    begin
        g2_next    = '0;
        g2_next.ax = px27 + $signed(rnd_x[26:0]);
        g2_next.ay = py27 + $signed(rnd_y[26:0]);
    end

    always_comb
    begin
        g3_next    = g2_reg;
        g3_next.dx = px28 + $signed({4'b0, ground_len_reg, 8'b0})
                     - $signed({g2_reg.ax[26], g2_reg.ax});
        g3_next.dy = py28 - $signed({g2_reg.ay[26], g2_reg.ay});
    end

    assign dxx    = g3_reg.dx * g3_reg.dx;
    assign dyy    = g3_reg.dy * g3_reg.dy;
    assign d2_sum = dxx_reg + dyy_reg;

    always_comb
    begin
        g5_next    = g4_reg;
        g5_next.d2 = d2_sum;
        g5_next.ok = (d2_sum != '0) && (d2_sum <= {4'b0, sum2_reg}) &&
                     (d2_sum >= {6'b0, dif2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (en)
            pv_reg <= {pv_reg[2:0], c_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_x_reg <= $signed({1'b0, crank_len_reg}) * c_cos;
            p1_y_reg <= $signed({1'b0, crank_len_reg}) * c_sin;
            g2_reg   <= g2_next;
            g3_reg   <= g3_next;
            g4_reg   <= g3_reg;
            dxx_reg  <= dxx[53:0];
            dyy_reg  <= dyy[53:0];
        end
    end

    // ------------------------------------------------------------------
    // Root of the squared distance
    // ------------------------------------------------------------------
    sq_t                sq1_reg [0:SQ1_STEPS];
    geo_t               sg1_reg [0:SQ1_STEPS];
    logic [SQ1_STEPS:0] sv1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv1_reg <= '0;
        else if (en)
            sv1_reg <= {sv1_reg[SQ1_STEPS-1:0], pv_reg[3]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg[0].rem  <= d2_sum;
            sq1_reg[0].root <= '0;
            sg1_reg[0]      <= g5_next;
        end
    end

    for (genvar gi = 0; gi < SQ1_STEPS; gi++)
    begin : g_sq1
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq1_reg[gi+1] <= sqrt_step(sq1_reg[gi], 54'd1 << (2 * SQ1_STEPS - 2 - 2 * gi));
                sg1_reg[gi+1] <= sg1_reg[gi];
            end
        end
    end

    // ------------------------------------------------------------------
    // Chord foot distance aa = num / (2 D)
    // ------------------------------------------------------------------
    geo_t               g6_next;
    geo_t               g6_reg;
    logic signed [54:0] num_reg;
    logic               v67_reg;
    logic [53:0]        num_mag;
    logic               num_ovf;
    geo_t               g7_next;

    always_comb
    begin
        g6_next       = sg1_reg[SQ1_STEPS];
        g6_next.droot = sq1_reg[SQ1_STEPS].root[26:0];
    end

    assign num_mag = num_reg[54] ? 54'(-num_reg) : num_reg[53:0];
    // Quotients too wide for the 25 quotient bits of the divider mark the item infeasible
    assign num_ovf = {1'b0, num_mag} >= {2'b0, g6_reg.droot, 1'b0, 25'b0};

    always_comb
    begin
        g7_next    = g6_reg;
        g7_next.ok = g6_reg.ok && !num_ovf;
    end

    dv_t                dv1_reg [0:DV1_STEPS];
    geo_t               dg1_reg [0:DV1_STEPS];
    logic [DV1_STEPS:0] dv1v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v67_reg  <= 1'b0;
            dv1v_reg <= '0;
        end
        else if (en)
        begin
            v67_reg  <= sv1_reg[SQ1_STEPS];
            dv1v_reg <= {dv1v_reg[DV1_STEPS-1:0], v67_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g6_reg         <= g6_next;
            num_reg        <= $signed({{6{bmc_reg[48]}}, bmc_reg})
                              + $signed({1'b0, sg1_reg[SQ1_STEPS].d2});
            dv1_reg[0].rem <= num_mag;
            dv1_reg[0].quo <= '0;
            dv1_reg[0].neg <= num_reg[54];
            dg1_reg[0]     <= g7_next;
        end
    end

    for (genvar gi = 0; gi < DV1_STEPS; gi++)
    begin : g_dv1
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv1_reg[gi+1] <= div_step(dv1_reg[gi], {26'b0, dg1_reg[gi].droot, 1'b0},
                                          DV1_STEPS - 1 - gi,
                                          26'd1 << (DV1_STEPS - 1 - gi));
                dg1_reg[gi+1] <= dg1_reg[gi];
            end
        end
    end

    // ------------------------------------------------------------------
    // Half chord hh = sqrt(b^2 - aa^2)
    // ------------------------------------------------------------------
    geo_t               g8_next;
    geo_t               g8_reg;
    geo_t               g9_reg;
    logic [49:0]        aasq_reg;
    logic signed [51:0] aasq;
    logic signed [50:0] hh2;
    geo_t               g10_next;
    logic [1:0]         v89_reg;

    always_comb
    begin
        g8_next    = dg1_reg[DV1_STEPS];
        g8_next.aa = dv1_reg[DV1_STEPS].neg ? -$signed(dv1_reg[DV1_STEPS].quo)
                                            : $signed(dv1_reg[DV1_STEPS].quo);
    end

    assign aasq = g8_reg.aa * g8_reg.aa;
    assign hh2  = $signed({3'b0, bsq_reg}) - $signed({1'b0, aasq_reg});

    always_comb
    begin
        g10_next    = g9_reg;
        g10_next.ok = g9_reg.ok && !hh2[50];
    end

    sq_t                sq2_reg [0:SQ2_STEPS];
    geo_t               sg2_reg [0:SQ2_STEPS];
    logic [SQ2_STEPS:0] sv2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v89_reg <= '0;
            sv2_reg <= '0;
        end
        else if (en)
        begin
            v89_reg <= {v89_reg[0], dv1v_reg[DV1_STEPS]};
            sv2_reg <= {sv2_reg[SQ2_STEPS-1:0], v89_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g8_reg          <= g8_next;
            g9_reg          <= g8_reg;
            aasq_reg        <= aasq[49:0];
            sq2_reg[0].rem  <= {6'b0, hh2[47:0]};
            sq2_reg[0].root <= '0;
            sg2_reg[0]      <= g10_next;
        end
    end

    for (genvar gi = 0; gi < SQ2_STEPS; gi++)
    begin : g_sq2
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq2_reg[gi+1] <= sqrt_step(sq2_reg[gi], 54'd1 << (2 * SQ2_STEPS - 2 - 2 * gi));
                sg2_reg[gi+1] <= sg2_reg[gi];
            end
        end
    end

    // ------------------------------------------------------------------
    // Projections and division by D
    // ------------------------------------------------------------------
    logic [23:0]        hh;
    geo_t               g11_reg;
    geo_t               g12_reg;
    logic signed [54:0] pr_adx_reg;
    logic signed [54:0] pr_hdy_reg;
    logic signed [54:0] pr_ady_reg;
    logic signed [54:0] pr_hdx_reg;
    logic signed [54:0] n_reg [4];
    dv4_t               n_lanes;
    logic [1:0]         v1112_reg;

    assign hh = sq2_reg[SQ2_STEPS].root[23:0];

    for (genvar gl = 0; gl < 4; gl++)
    begin : g_lane
        assign n_lanes[gl].rem = n_reg[gl][54] ? 54'(-n_reg[gl]) : n_reg[gl][53:0];
        assign n_lanes[gl].quo = '0;
        assign n_lanes[gl].neg = n_reg[gl][54];
    end

    dv4_t               dv2_reg [0:DV2_STEPS];
    geo_t               dg2_reg [0:DV2_STEPS];
    logic [DV2_STEPS:0] dv2v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1112_reg <= '0;
            dv2v_reg  <= '0;
        end
        else if (en)
        begin
            v1112_reg <= {v1112_reg[0], sv2_reg[SQ2_STEPS]};
            dv2v_reg  <= {dv2v_reg[DV2_STEPS-1:0], v1112_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g11_reg    <= sg2_reg[SQ2_STEPS];
            pr_adx_reg <= sg2_reg[SQ2_STEPS].aa * sg2_reg[SQ2_STEPS].dx;
            pr_hdy_reg <= $signed({1'b0, hh}) * sg2_reg[SQ2_STEPS].dy;
            pr_ady_reg <= sg2_reg[SQ2_STEPS].aa * sg2_reg[SQ2_STEPS].dy;
            pr_hdx_reg <= $signed({1'b0, hh}) * sg2_reg[SQ2_STEPS].dx;
            g12_reg    <= g11_reg;
            n_reg[0]   <= pr_adx_reg - pr_hdy_reg;   // B0 x
            n_reg[1]   <= pr_ady_reg + pr_hdx_reg;   // B0 y
            n_reg[2]   <= pr_adx_reg + pr_hdy_reg;   // B1 x
            n_reg[3]   <= pr_ady_reg - pr_hdx_reg;   // B1 y
            dv2_reg[0] <= n_lanes;
            dg2_reg[0] <= g12_reg;
        end
    end

    for (genvar gi = 0; gi < DV2_STEPS; gi++)
    begin : g_dv2
        for (genvar gl = 0; gl < 4; gl++)
        begin : g_dv2_lane
            always_ff @(posedge clk)
            begin
                if (en)
                    dv2_reg[gi+1][gl] <= div_step(dv2_reg[gi][gl],
                                                  {27'b0, dg2_reg[gi].droot},
                                                  DV2_STEPS - 1 - gi,
                                                  26'd1 << (DV2_STEPS - 1 - gi));
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                dg2_reg[gi+1] <= dg2_reg[gi];
        end
    end

    // ------------------------------------------------------------------
    // Intersection points, case selection and output register
    // ------------------------------------------------------------------
    logic signed [26:0] q_sgn [4];
    logic signed [27:0] b_reg [4];
    geo_t               g14_reg;
    logic               v14_reg;
    logic signed [27:0] ax28;
    logic signed [27:0] ay28;
    logic signed [27:0] ox [3];
    logic signed [27:0] oy [3];
    logic               feas;
    logic [119:0]       m_tdata_reg;
    logic               m_tuser_reg;

    for (genvar gl = 0; gl < 4; gl++)
    begin : g_q
        assign q_sgn[gl] = dv2_reg[DV2_STEPS][gl].neg ?
                           -$signed({1'b0, dv2_reg[DV2_STEPS][gl].quo}) :
                           $signed({1'b0, dv2_reg[DV2_STEPS][gl].quo});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g14_reg  <= dg2_reg[DV2_STEPS];
            b_reg[0] <= $signed({dg2_reg[DV2_STEPS].ax[26], dg2_reg[DV2_STEPS].ax})
                        + $signed({q_sgn[0][26], q_sgn[0]});
            b_reg[1] <= $signed({dg2_reg[DV2_STEPS].ay[26], dg2_reg[DV2_STEPS].ay})
                        + $signed({q_sgn[1][26], q_sgn[1]});
            b_reg[2] <= $signed({dg2_reg[DV2_STEPS].ax[26], dg2_reg[DV2_STEPS].ax})
                        + $signed({q_sgn[2][26], q_sgn[2]});
            b_reg[3] <= $signed({dg2_reg[DV2_STEPS].ay[26], dg2_reg[DV2_STEPS].ay})
                        + $signed({q_sgn[3][26], q_sgn[3]});
        end
    end

    assign ax28 = $signed({g14_reg.ax[26], g14_reg.ax});
    assign ay28 = $signed({g14_reg.ay[26], g14_reg.ay});

    always_comb
    begin
        feas = 1'b0;
        if (zero_len)
        begin
            // Degenerate linkage: collapse every point onto the crank pivot
            ox[0] = px28;
            oy[0] = py28;
            ox[1] = px28;
            oy[1] = py28;
            ox[2] = px28;
            oy[2] = py28;
        end
        else
        begin
            ox[0] = ax28;
            oy[0] = ay28;
            ox[1] = g14_reg.ok ? b_reg[0] : ax28;
            oy[1] = g14_reg.ok ? b_reg[1] : ay28;
            ox[2] = g14_reg.ok ? b_reg[2] : ax28;
            oy[2] = g14_reg.ok ? b_reg[3] : ay28;
            feas  = g14_reg.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v14_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v14_reg      <= dv2v_reg[DV2_STEPS];
            m_tvalid_reg <= v14_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {emit(oy[2]), emit(ox[2]), emit(oy[1]), emit(ox[1]),
                            emit(oy[0]), emit(ox[0])};
            m_tuser_reg <= feas;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fbps_cordic.sv @@
// ============================================================================
// fbps_cordic
// Pipelined rotation unit: cosine and sine of a turn fraction, Q1.30.
// ============================================================================
`default_nettype none

module fbps_cordic
    import fbps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [15:0]        angle,
    output logic               out_valid,
    output logic signed [32:0] cos_val,
    output logic signed [32:0] sin_val
);

    function automatic cordic_t cordic_iter(input cordic_t s, input int sh,
                                            input logic signed [31:0] atn);
        cordic_t r;
        r.quad = s.quad;
        if (s.z >= 0)
        begin
            r.x = s.x - (s.y >>> sh);
            r.y = s.y + (s.x >>> sh);
            r.z = s.z - atn;
        end
        else
        begin
            r.x = s.x + (s.y >>> sh);
            r.y = s.y - (s.x >>> sh);
            r.z = s.z + atn;
        end
        return r;
    endfunction

    logic [31:0]           ang32;
    cordic_t               st_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] vld_reg;
    logic                  out_valid_reg;
    logic signed [32:0]    cos_reg;
    logic signed [32:0]    sin_reg;

    assign ang32 = {angle[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[CORDIC_STEPS-1:0], in_valid};
            out_valid_reg <= vld_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].x    <= CORDIC_X0;
            st_reg[0].y    <= '0;
            st_reg[0].z    <= $signed({2'b00, ang32[29:0]});
            st_reg[0].quad <= ang32[31:30];
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[gi+1] <= cordic_iter(st_reg[gi], gi, ATAN_TURN[gi]);
        end
    end

    // Fold the first-quadrant result out to the full turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (st_reg[CORDIC_STEPS].quad)
                2'd0:
                begin
                    cos_reg <= st_reg[CORDIC_STEPS].x;
                    sin_reg <= st_reg[CORDIC_STEPS].y;
                end
                2'd1:
                begin
                    cos_reg <= -st_reg[CORDIC_STEPS].y;
                    sin_reg <= st_reg[CORDIC_STEPS].x;
                end
                2'd2:
                begin
                    cos_reg <= -st_reg[CORDIC_STEPS].x;
                    sin_reg <= -st_reg[CORDIC_STEPS].y;
                end
                default:
                begin
                    cos_reg <= st_reg[CORDIC_STEPS].y;
                    sin_reg <= -st_reg[CORDIC_STEPS].x;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fbps_checker.sv @@
// ============================================================================
// fbps_checker
// Port-level checks of the four-bar position solver, bound to the top level.
// ============================================================================
`default_nettype none

module fbps_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire [15:0]  s_tdata,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [119:0] m_tdata,
    input wire         m_tuser,
    input wire         cfg_valid,
    input wire         cfg_ready,
    input wire [2:0]   cfg_index,
    input wire [15:0]  cfg_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input side advances exactly when the output register can move
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // Without closure both roots sit on joint A
    a_infeasible_roots: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            (m_tdata[59:40] == m_tdata[19:0]) && (m_tdata[79:60] == m_tdata[39:20]) &&
            (m_tdata[99:80] == m_tdata[19:0]) && (m_tdata[119:100] == m_tdata[39:20]))
        else $error("infeasible result with roots away from joint A");

endmodule

bind four_bar_position_solver fbps_checker u_fbps_checker (.*);

`default_nettype wire
